// File: rtl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg : shared types and constants
// Widths, opcodes, status codes, sequencer states, divider types and class weights of the scheduler.
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int TARGET_LATENCY = 48;
    localparam int IDX_W          = $clog2(QUEUE_DEPTH);
    localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W          = 40;
    localparam int WGT_W          = 17;
    localparam int TOT_W          = 22;
    localparam int DIV_W          = 42;
    localparam int DIV_CNT_W      = $clog2(DIV_W + 1);

    localparam logic signed [TOT_W-1:0] TOTAL_MIN = {1'b1, {(TOT_W-1){1'b0}}};
    localparam logic signed [TOT_W-1:0] TOTAL_MAX = {1'b0, {(TOT_W-1){1'b1}}};

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic [1:0] ST_SELECTED = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_ADDED    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [2:0] {
        t_IDLE, t_KEY_DIV, t_SCAN, t_SLICE_DIV, t_REMOVE, t_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } t_div_rsp;

    function automatic logic [WGT_W-1:0] class_weight(input logic [1:0] p);
        logic [WGT_W-1:0] w;
        unique case (p)
            2'd0:    w = WGT_W'(88761);
            2'd1:    w = WGT_W'(29154);
            2'd2:    w = WGT_W'(1024);
            default: w = WGT_W'(15);
        endcase
        return w;
    endfunction

endpackage

// File: rtl/fss_divider.sv
// ----------------------------------------------------------------------------
// fss_divider : shared restoring divider
// One quotient bit per cycle, unsigned, for both key and slice.
// ----------------------------------------------------------------------------
module fss_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fss_pkg::t_div_req i_req,
    output fss_pkg::t_div_rsp o_rsp
);
    import fss_pkg::*;

    logic [DIV_W-1:0]     r_rem, n_rem, r_quo, n_quo, r_den, n_den;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy, r_done, n_done;
    logic [DIV_W:0]       w_trial;

    always_comb begin
        n_rem = r_rem; n_quo = r_quo; n_den = r_den;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_rem, r_quo[DIV_W-1]} - {1'b0, r_den};
        if (i_req.start) begin
            n_rem = '0; n_quo = i_req.dividend; n_den = i_req.divisor;
            n_cnt = DIV_CNT_W'(DIV_W); n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[DIV_W]) begin
                n_rem = w_trial[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_quo <= n_quo; r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// File: rtl/fair_share_scheduler.sv
// ----------------------------------------------------------------------------
// fair_share_scheduler : virtual-runtime ready queue
// Iterative scheduler with one shared serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command transaction: add a thread (key computed from
//   service time and priority weight) or select the thread of least key.
//   m_axis returns exactly one result transaction per command.
//   i_cfg_we/i_cfg_wdata write min_slice; write only while idle.
// Command flow (receiver always ready):
//   add          : accept, key division in the divider, output
//   full add     : accept, output
//   empty select : accept, output
//   select       : accept, scan of the queue entries, slice division,
//                  remove pass over the entries, output
//   The serial divider produces one quotient bit per cycle; only
//   one command is in flight, s_axis_tready is low while it works.
// Reset: queue empty, weight total zero, min_slice 3.
// Stall: the result is held in the output register until m_axis_tready;
//   no new command is taken meanwhile.
// ----------------------------------------------------------------------------
module fair_share_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: opcode[0], thread_id[8:1], priority_req[10:9], is_ready[11],
    //        run_ticks[27:12], zero pad [31:28]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: status[1:0], chosen_id[9:2], slice[17:10], chosen_key[57:18],
    //        entries_before[62:58], zero pad [63]
    output logic [63:0] m_axis_tdata
);
    import fss_pkg::*;

    t_state r_state, n_state;

    // queue storage, each entry read by a scanning index
    logic [KEY_W-1:0] r_key [QUEUE_DEPTH];
    logic [7:0]       r_id  [QUEUE_DEPTH];
    logic [WGT_W-1:0] r_wgt [QUEUE_DEPTH];
    logic [IDX_W-1:0] r_age [QUEUE_DEPTH];

    logic [CNT_W-1:0]       r_count;
    logic signed [TOT_W-1:0] r_total;
    logic [7:0]             r_min_slice;

    // captured command
    logic [7:0]       r_tid;
    logic [WGT_W-1:0] r_w;
    logic [15:0]      r_svc;

    // scan and result
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] r_best;
    logic [1:0]       r_status;
    logic [7:0]       r_cid, r_slice;
    logic [KEY_W-1:0] r_ckey;
    logic [CNT_W-1:0] r_before;
    logic             r_out_valid;

    t_div_req w_req;
    t_div_rsp w_rsp;

    fss_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    logic w_in_fire, w_out_fire;
    assign s_axis_tready = (r_state == t_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_fire    = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_before, r_ckey, r_slice, r_cid, r_status};

    logic [IDX_W-1:0] w_idx, w_last;
    assign w_idx  = r_idx[IDX_W-1:0];
    assign w_last = IDX_W'(r_count - 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_IDLE: if (w_in_fire) begin
                if (s_axis_tdata[0] == OP_ADD)
                    n_state = (r_count >= CNT_W'(QUEUE_DEPTH)) ? t_OUT : t_KEY_DIV;
                else
                    n_state = (r_count == '0) ? t_OUT : t_SCAN;
            end
            t_KEY_DIV:   if (w_rsp.done) n_state = t_OUT;
            t_SCAN:      if (r_idx >= r_count) n_state = t_SLICE_DIV;
            t_SLICE_DIV: if (w_rsp.done) n_state = t_REMOVE;
            t_REMOVE:    if (r_idx >= r_count) n_state = t_OUT;
            t_OUT:       if (w_out_fire) n_state = t_IDLE;
            default:     n_state = t_IDLE;
        endcase
    end

    // divider requests: start on every accepted add (a full one too) and at the end of the scan
    logic signed [TOT_W:0]  w_sum;
    logic [TOT_W+CNT_W-1:0] w_den;
    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = '0;
        w_req.divisor  = '0;
        w_den = (r_total[TOT_W-1] ? '0 : (TOT_W+CNT_W)'(r_total)) * (TOT_W+CNT_W)'(r_count);
        if (r_state == t_IDLE && w_in_fire && s_axis_tdata[0] == OP_ADD) begin
            w_req.start    = 1'b1;
            w_req.dividend = DIV_W'({s_axis_tdata[27:12], 26'b0});
            w_req.divisor  = DIV_W'(class_weight(s_axis_tdata[10:9]));
        end else if (r_state == t_SCAN && r_idx >= r_count) begin
            w_req.start    = 1'b1;
            w_req.dividend = DIV_W'(r_wgt[r_best]) * DIV_W'(TARGET_LATENCY);
            w_req.divisor  = DIV_W'(w_den);
        end
        w_sum = 23'(r_total) + (r_state == t_IDLE ? 23'(class_weight(s_axis_tdata[10:9]))
                                                  : -23'(r_w));
    end

    function automatic logic signed [TOT_W-1:0] clamp(input logic signed [TOT_W:0] v);
        logic signed [TOT_W-1:0] r;
        if (v < 23'(TOTAL_MIN)) r = TOTAL_MIN;
        else if (v > 23'(TOTAL_MAX)) r = TOTAL_MAX;
        else r = TOT_W'(v);
        return r;
    endfunction

    logic w_better;
    assign w_better = (r_key[w_idx] < r_key[r_best]) ||
                      (r_key[w_idx] == r_key[r_best] && r_age[w_idx] < r_age[r_best]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE; r_count <= '0; r_total <= '0;
            r_min_slice <= 8'd3; r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_min_slice <= i_cfg_wdata;
            if (w_out_fire) r_out_valid <= 1'b0;
            unique case (r_state)
                t_IDLE: if (w_in_fire) begin
                    r_tid <= s_axis_tdata[8:1];
                    r_w <= class_weight(s_axis_tdata[10:9]);
                    r_svc <= s_axis_tdata[27:12];
                    r_before <= r_count;
                    r_cid <= '0; r_slice <= '0; r_ckey <= '0;
                    r_idx <= CNT_W'(1); r_best <= '0;
                    if (s_axis_tdata[0] == OP_ADD) begin
                        if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                            r_status <= ST_FULL; r_out_valid <= 1'b1;
                        end else begin
                            r_status <= ST_ADDED;
                            if (s_axis_tdata[11]) r_total <= clamp(w_sum);
                        end
                    end else if (r_count == '0) begin
                        r_status <= ST_EMPTY; r_out_valid <= 1'b1;
                    end else begin
                        r_status <= ST_SELECTED;
                    end
                end
                t_KEY_DIV: if (w_rsp.done) begin
                    r_key[r_count[IDX_W-1:0]] <= w_rsp.quotient[KEY_W-1:0];
                    r_id[r_count[IDX_W-1:0]]  <= r_tid;
                    r_wgt[r_count[IDX_W-1:0]] <= r_w;
                    r_age[r_count[IDX_W-1:0]] <= r_count[IDX_W-1:0];
                    r_count <= r_count + 1'b1;
                    r_out_valid <= 1'b1;
                end
                t_SCAN: begin
                    if (r_idx < r_count) begin
                        if (w_better) r_best <= w_idx;
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_w <= r_wgt[r_best]; r_cid <= r_id[r_best];
                        r_ckey <= r_key[r_best];
                    end
                end
                t_SLICE_DIV: if (w_rsp.done) begin
                    // slice = max(min, q) then saturate; min when total <= 0
                    if (r_total <= 0) r_slice <= r_min_slice;
                    else if (w_rsp.quotient > DIV_W'(255)) r_slice <= 8'hFF;
                    else if (w_rsp.quotient[7:0] < r_min_slice) r_slice <= r_min_slice;
                    else r_slice <= w_rsp.quotient[7:0];
                    r_total <= clamp(w_sum);
                    // move last entry into the freed slot
                    r_key[r_best] <= r_key[w_last]; r_id[r_best] <= r_id[w_last];
                    r_wgt[r_best] <= r_wgt[w_last]; r_age[r_best] <= r_age[w_last];
                    r_svc <= 16'(r_age[r_best]);
                    r_count <= r_count - 1'b1;
                    r_idx <= '0;
                end
                t_REMOVE: begin
                    // close the age gap, one entry per cycle
                    if (r_idx < r_count) begin
                        if (r_age[w_idx] > r_svc[IDX_W-1:0])
                            r_age[w_idx] <= r_age[w_idx] - 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                t_OUT: ;
                default: ;
            endcase
        end
    end
endmodule
